// ----- src/fpfa_pkg.sv -----
// Shared types and constants for the fixed partition fit allocator.
package fpfa_pkg;

  localparam int unsigned Partitions = 16;
  localparam int unsigned IdxW       = $clog2(Partitions);
  localparam int unsigned CntW       = $clog2(Partitions + 1);
  localparam int unsigned SizeW      = 16;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 5;

  typedef enum logic [1:0] {
    PolFirst = 2'd0,
    PolBest  = 2'd1,
    PolNext  = 2'd2,
    PolWorst = 2'd3
  } policy_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPolicy = 2'd0,
    CfgCount  = 2'd1,
    CfgRsvd2  = 2'd2,
    CfgRsvd3  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate
  } state_e;

  typedef struct packed {
    logic fits;
    logic take;
  } fit_res_t;

endpackage

// ----- src/fpfa_ram.sv -----
// Generic single write, single read RAM with registered read data.
module fpfa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fpfa_fit_unit.sv -----
// Shared fit comparator: checks one candidate against the request and the best so far.
module fpfa_fit_unit (
  input  fpfa_pkg::policy_e                policy_i,
  input  logic [fpfa_pkg::SizeW-1:0]       amount_i,
  input  logic [fpfa_pkg::SizeW-1:0]       cand_i,
  input  logic [fpfa_pkg::SizeW-1:0]       best_i,
  input  logic                             found_i,
  output fpfa_pkg::fit_res_t               res_o
);
  import fpfa_pkg::*;

  logic better;

  always_comb begin
    unique case (policy_i)
      PolBest:  better = cand_i < best_i;
      PolWorst: better = cand_i > best_i;
      PolFirst: better = 1'b0;
      PolNext:  better = 1'b0;
      default:  better = 1'b0;
    endcase
    res_o.fits = amount_i <= cand_i;
    res_o.take = res_o.fits && (!found_i || better);
  end

endmodule

// ----- src/fixed_partition_fit_allocator.sv -----
// Top level of the fixed partition fit allocator: sequencer, state and result register.
// Load: result strobed on done_o the cycle after the transfer; busy stays low.
// Request: at most one RAM read and one compare per partition in use; first and next fit
//   stop at the first hit, and done_o is registered from StUpdate after the scan.
// busy holds off the next transfer until done_o is high, so requests never overlap.
// Reset: first fit, sixteen partitions, roving pointer 0; free sizes undefined until loaded.
module fixed_partition_fit_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command side
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind_i,
  input  logic [fpfa_pkg::SlotW-1:0]      slot_i,
  input  logic [fpfa_pkg::SizeW-1:0]      amount_i,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [fpfa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fpfa_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // result
  output logic                            done_o,
  output logic                            granted_o,
  output logic [fpfa_pkg::SlotW-1:0]      chosen_slot_o,
  output logic [fpfa_pkg::SizeW-1:0]      hole_o
);
  import fpfa_pkg::*;

  // configuration registers
  policy_e          policy_q;
  logic [4:0]       count_q;

  // sequencer state
  state_e           state_q, state_d;
  logic [IdxW-1:0]  rov_q, rov_d;         // roving pointer for next fit
  logic [CntW-1:0]  n_q, n_d;             // partitions in use for this request
  logic [IdxW-1:0]  addr_q, addr_d;       // next partition to read
  logic [CntW-1:0]  issued_q, issued_d;   // reads issued so far
  logic             evld_q, evld_d;       // read data valid this cycle
  logic [IdxW-1:0]  eidx_q, eidx_d;       // index of that read data
  logic             found_q, found_d;
  logic [IdxW-1:0]  pick_q, pick_d;
  logic [SizeW-1:0] best_q, best_d;
  logic [SizeW-1:0] amount_q, amount_d;

  // result register
  logic             done_q, done_d;
  logic             granted_q, granted_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SizeW-1:0] hole_q, hole_d;

  // RAM port signals
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [SizeW-1:0] ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [SizeW-1:0] ram_rdata;

  fit_res_t         fit;
  logic             accept;
  logic             early_stop;
  logic             issue;
  logic [CntW-1:0]  n_use;
  logic [CntW-1:0]  addr_inc;
  logic [CntW-1:0]  slot_ext;

  fpfa_ram #(
    .Width (SizeW),
    .Depth (Partitions)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fpfa_fit_unit u_fit (
    .policy_i (policy_q),
    .amount_i (amount_q),
    .cand_i   (ram_rdata),
    .best_i   (best_q),
    .found_i  (found_q),
    .res_o    (fit)
  );

  // configuration writes; indices beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolFirst;
      count_q  <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPolicy: policy_q <= policy_e'(cfg_wdata_i[1:0]);
        CfgCount:  count_q  <= cfg_wdata_i;
        CfgRsvd2:  ;
        CfgRsvd3:  ;
        default:   ;
      endcase
    end
  end

  assign busy   = state_q != StIdle;
  assign accept = start && !busy;

  // partitions in use: count clipped to the storage depth
  assign n_use    = ({1'b0, count_q} > 6'(Partitions)) ? CntW'(Partitions)
                                                        : CntW'(count_q);
  assign addr_inc = CntW'(addr_q) + CntW'(1);
  assign slot_ext = CntW'(slot_i);

  always_comb begin
    state_d   = state_q;
    rov_d     = rov_q;
    n_d       = n_q;
    addr_d    = addr_q;
    issued_d  = issued_q;
    evld_d    = 1'b0;
    eidx_d    = eidx_q;
    found_d   = found_q;
    pick_d    = pick_q;
    best_d    = best_q;
    amount_d  = amount_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    slot_d    = slot_q;
    hole_d    = hole_q;
    ram_we    = 1'b0;
    ram_waddr = pick_q;
    ram_wdata = best_q - amount_q;
    ram_raddr = addr_q;
    early_stop = 1'b0;
    issue      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (!kind_i) begin
            // load: write the entry (when it exists) and echo it
            ram_we    = slot_ext < CntW'(Partitions);
            ram_waddr = slot_i[IdxW-1:0];
            ram_wdata = amount_i;
            rov_d     = '0;
            done_d    = 1'b1;
            granted_d = 1'b0;
            slot_d    = slot_i;
            hole_d    = amount_i;
          end else begin
            amount_d = amount_i;
            n_d      = n_use;
            // only next fit starts at the roving pointer; the rest scan from 0
            addr_d   = (policy_q == PolNext && CntW'(rov_q) < n_use) ? rov_q : '0;
            issued_d = '0;
            found_d  = 1'b0;
            pick_d   = '0;
            best_d   = '0;
            state_d  = StScan;
          end
        end
      end

      StScan: begin
        // evaluate last cycle's read while the next one is issued
        if (evld_q && fit.take) begin
          found_d = 1'b1;
          pick_d  = eidx_q;
          best_d  = ram_rdata;
        end
        early_stop = (policy_q == PolFirst || policy_q == PolNext) &&
                     (found_q || (evld_q && fit.take));
        issue = !early_stop && (issued_q < n_q);
        if (issue) begin
          ram_raddr = addr_q;
          eidx_d    = addr_q;
          evld_d    = 1'b1;
          issued_d  = issued_q + CntW'(1);
          addr_d    = (addr_inc >= n_q) ? '0 : addr_inc[IdxW-1:0];
        end else begin
          state_d = StUpdate;
        end
      end

      StUpdate: begin
        done_d = 1'b1;
        if (found_q) begin
          ram_we    = 1'b1;
          granted_d = 1'b1;
          slot_d    = SlotW'(pick_q);
          hole_d    = best_q - amount_q;
          if (policy_q == PolNext) begin
            rov_d = pick_q;
          end
        end else begin
          granted_d = 1'b0;
          slot_d    = '0;
          hole_d    = '0;
        end
        state_d = StIdle;
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rov_q    <= '0;
      evld_q   <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
      n_q      <= '0;
      addr_q   <= '0;
      issued_q <= '0;
    end else begin
      state_q  <= state_d;
      rov_q    <= rov_d;
      evld_q   <= evld_d;
      found_q  <= found_d;
      done_q   <= done_d;
      n_q      <= n_d;
      addr_q   <= addr_d;
      issued_q <= issued_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    eidx_q    <= eidx_d;
    pick_q    <= pick_d;
    best_q    <= best_d;
    amount_q  <= amount_d;
    granted_q <= granted_d;
    slot_q    <= slot_d;
    hole_q    <= hole_d;
  end

  assign done_o        = done_q;
  assign granted_o     = granted_q;
  assign chosen_slot_o = slot_q;
  assign hole_o        = hole_q;

endmodule

// ----- verif/tb_fixed_partition_fit_allocator.sv -----
// Self-checking testbench for the fixed partition fit allocator: directed table, then random phases.
module tb_fixed_partition_fit_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import fpfa_pkg::*;

  // Item kinds as carried on kind_i
  localparam logic KindLoad    = 1'b0;
  localparam logic KindRequest = 1'b1;

  localparam int unsigned RandItems     = 1350;
  // final stretch of the random part runs with no gaps on the command side
  localparam int unsigned TailItems     = 150;
  localparam int unsigned SettleCycles  = 3;
  // the limit is many times the longest request or gap
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxReports    = 10;

  typedef struct packed {
    logic             granted;
    logic [SlotW-1:0] slot;
    logic [SizeW-1:0] hole;
  } alloc_res_t;

  // one row of the directed table: either a register write or an item
  typedef struct {
    bit                   is_cfg;
    cfg_idx_e             idx;
    logic [CfgDataW-1:0]  data;
    logic                 kind;
    logic [SlotW-1:0]     slot;
    logic [SizeW-1:0]     amount;
    bit                   typed;
    alloc_res_t           want;
  } plan_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 kind_i      = 1'b0;
  logic [SlotW-1:0]     slot_i      = '0;
  logic [SizeW-1:0]     amount_i    = '0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 busy;
  logic                 done_o;
  logic                 granted_o;
  logic [SlotW-1:0]     chosen_slot_o;
  logic [SizeW-1:0]     hole_o;

  fixed_partition_fit_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .slot_i        (slot_i),
    .amount_i      (amount_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .granted_o     (granted_o),
    .chosen_slot_o (chosen_slot_o),
    .hole_o        (hole_o)
  );

  // Shadow of the allocator: free sizes, roving pointer and both registers
  logic [SizeW-1:0]    free_space [Partitions];
  logic [IdxW-1:0]     rover;
  policy_e             fit_mode;
  logic [CfgDataW-1:0] part_count;

  alloc_res_t expected_grants [$];
  plan_row_t  dir_plan [$];
  alloc_res_t seen_want;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Work out the result of one accepted item and update the shadow state.
  function automatic alloc_res_t predict_allocation(input logic             kind,
                                                    input logic [SlotW-1:0] slot,
                                                    input logic [SizeW-1:0] amount);
    alloc_res_t  res;
    int unsigned n;
    int unsigned pos;
    int unsigned pick;
    bit          found;
    res   = '0;
    found = 1'b0;
    pick  = 0;
    // counts above the storage size clamp to it; zero means nothing searched
    n = (part_count > Partitions) ? Partitions : part_count;
    if (kind == KindLoad) begin
      free_space[slot] = amount;
      rover            = '0;
      res.slot         = slot;
      res.hole         = amount;
      return res;
    end
    if (fit_mode == PolNext) begin
      // a pointer left beyond the count restarts the scan at partition 0
      pos = (rover < n) ? rover : 0;
      for (int i = 0; i < n; i++) begin
        if (amount <= free_space[pos]) begin
          found = 1'b1;
          pick  = pos;
          break;
        end
        pos = (pos + 1 >= n) ? 0 : pos + 1;
      end
      if (found) rover = pick[IdxW-1:0];
    end else begin
      for (int i = 0; i < n; i++) begin
        if (amount <= free_space[i]) begin
          if (!found) begin
            found = 1'b1;
            pick  = i;
            if (fit_mode == PolFirst) break;
          end else if (fit_mode == PolBest && free_space[i] < free_space[pick]) begin
            pick = i;
          end else if (fit_mode == PolWorst && free_space[i] > free_space[pick]) begin
            pick = i;
          end
        end
      end
    end
    // a refused request leaves everything as it was and answers all zeros
    if (found) begin
      free_space[pick] = free_space[pick] - amount;
      res.granted      = 1'b1;
      res.slot         = pick[SlotW-1:0];
      res.hole         = free_space[pick];
    end
    return res;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    r.kind   = KindLoad;
    r.slot   = '0;
    r.amount = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic kind, input logic [SlotW-1:0] slot,
                                         input logic [SizeW-1:0] amount, input bit typed,
                                         input alloc_res_t want);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = CfgPolicy;
    r.data   = '0;
    r.kind   = kind;
    r.slot   = slot;
    r.amount = amount;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  // a load always echoes its slot and size with no grant
  function automatic plan_row_t load_row(input logic [SlotW-1:0] slot,
                                         input logic [SizeW-1:0] amount);
    return item_row(KindLoad, slot, amount, 1'b1, '{granted: 1'b0, slot: slot, hole: amount});
  endfunction

  // Offer one item; returns at the edge where the transfer happens, start still high.
  task automatic transfer_item(input logic kind, input logic [SlotW-1:0] slot,
                               input logic [SizeW-1:0] amount, input bit typed,
                               input alloc_res_t want);
    alloc_res_t guess;
    @(negedge clk_i);
    start    <= 1'b1;
    kind_i   <= kind;
    slot_i   <= slot;
    amount_i <= amount;
    do @(posedge clk_i); while (busy);
    guess = predict_allocation(kind, slot, amount);
    expected_grants.push_back(typed ? want : guess);
  endtask

  task automatic pause_sender();
    @(negedge clk_i);
    start <= 1'b0;
    repeat ($urandom_range(1, 16)) @(posedge clk_i);
  endtask

  // Every item answers, so an empty queue plus a short settle means idle.
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgPolicy: fit_mode   = policy_e'(data[1:0]);
      CfgCount:  part_count = data;
      default: ;  // reserved indexes change nothing
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input alloc_res_t want);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("%0t %s: want g=%0d slot=%0d hole=%0d, got g=%0d slot=%0d hole=%0d",
               $realtime, what, want.granted, want.slot, want.hole,
               granted_o, chosen_slot_o, hole_o);
    end
  endtask

  // Result side: one strobe per result, cannot be held off, checked in order.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_grants.size() == 0) begin
        flag_mismatch("result with nothing outstanding", '0);
      end else begin
        seen_want = expected_grants.pop_front();
        if (granted_o !== seen_want.granted || chosen_slot_o !== seen_want.slot ||
            hole_o !== seen_want.hole) begin
          flag_mismatch("result mismatch", seen_want);
        end
      end
    end
  end

  // Watchdog: any command transfer or result strobe counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned load_pct;
    int unsigned pick;
    bit          idle_on;
    logic                kind;
    logic [SlotW-1:0]    slot;
    logic [SizeW-1:0]    amount;
    logic [CfgDataW-1:0] cnt;

    // shadow reset: first fit, sixteen partitions, pointer at 0
    fit_mode   = PolFirst;
    part_count = CfgDataW'(Partitions);
    rover      = '0;
    for (int i = 0; i < Partitions; i++) free_space[i] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Every partition is loaded first so no request ever
    // reads an entry that was never written.
    dir_plan.push_back(load_row(4'd0,  16'd100));
    dir_plan.push_back(load_row(4'd1,  16'd0));
    dir_plan.push_back(load_row(4'd2,  16'd65535));
    dir_plan.push_back(load_row(4'd3,  16'd40));
    dir_plan.push_back(load_row(4'd4,  16'd200));
    dir_plan.push_back(load_row(4'd5,  16'd40));
    dir_plan.push_back(load_row(4'd6,  16'd7));
    dir_plan.push_back(load_row(4'd7,  16'd1000));
    dir_plan.push_back(load_row(4'd8,  16'd30));
    dir_plan.push_back(load_row(4'd9,  16'd500));
    dir_plan.push_back(load_row(4'd10, 16'd5));
    dir_plan.push_back(load_row(4'd11, 16'd60));
    dir_plan.push_back(load_row(4'd12, 16'd900));
    dir_plan.push_back(load_row(4'd13, 16'd15));
    dir_plan.push_back(load_row(4'd14, 16'd2000));
    dir_plan.push_back(load_row(4'd15, 16'd65534));
    // no partition in use: even a zero-size request is refused
    dir_plan.push_back(cfg_row(CfgCount, 5'd0));
    dir_plan.push_back(item_row(KindRequest, 4'd15, 16'd0, 1'b1, '0));
    // count above storage clamps; reserved indexes must be ignored
    dir_plan.push_back(cfg_row(CfgCount, 5'd31));
    dir_plan.push_back(cfg_row(CfgRsvd2, 5'd31));
    dir_plan.push_back(cfg_row(CfgRsvd3, 5'd0));
    // zero-size request fits the first partition and leaves it unchanged
    dir_plan.push_back(item_row(KindRequest, 4'd0, 16'd0, 1'b0, '0));
    dir_plan.push_back(item_row(KindRequest, 4'd0, 16'd65535, 1'b0, '0));
    // the only full-size partition is now empty: refused
    dir_plan.push_back(item_row(KindRequest, 4'd0, 16'd65535, 1'b1, '0));
    dir_plan.push_back(cfg_row(CfgPolicy, 5'(PolBest)));
    dir_plan.push_back(item_row(KindRequest, 4'd0, 16'd40, 1'b0, '0));
    dir_plan.push_back(cfg_row(CfgPolicy, 5'(PolWorst)));
    dir_plan.push_back(item_row(KindRequest, 4'd0, 16'd1, 1'b0, '0));
    // next fit: pointer moves onto partition 4 and stays there
    dir_plan.push_back(cfg_row(CfgPolicy, 5'(PolNext)));
    dir_plan.push_back(cfg_row(CfgCount, 5'd8));
    dir_plan.push_back(item_row(KindRequest, 4'd0, 16'd150, 1'b0, '0));
    dir_plan.push_back(item_row(KindRequest, 4'd0, 16'd45, 1'b0, '0));
    // pointer now beyond the count: scan restarts at partition 0
    dir_plan.push_back(cfg_row(CfgCount, 5'd3));
    dir_plan.push_back(item_row(KindRequest, 4'd0, 16'd5, 1'b0, '0));
    // load outside the searched range still lands and resets the pointer
    dir_plan.push_back(load_row(4'd9, 16'd123));
    dir_plan.push_back(cfg_row(CfgCount, 5'd16));
    dir_plan.push_back(item_row(KindRequest, 4'd0, 16'd123, 1'b0, '0));

    foreach (dir_plan[i]) begin
      if (dir_plan[i].is_cfg) begin
        wait_drained();
        write_cfg(dir_plan[i].idx, dir_plan[i].data);
      end else begin
        transfer_item(dir_plan[i].kind, dir_plan[i].slot, dir_plan[i].amount,
                      dir_plan[i].typed, dir_plan[i].want);
      end
    end

    // Random part: phases with fresh settings, written only once drained.
    sent = 0;
    while (sent < RandItems) begin
      phase_len = $urandom_range(40, 120);
      load_pct  = $urandom_range(10, 50);
      idle_on   = (sent + TailItems < RandItems) && ($urandom_range(0, 3) != 0);
      wait_drained();
      write_cfg(CfgPolicy, CfgDataW'($urandom_range(0, 3)));
      pick = $urandom_range(0, 9);
      case (pick)
        0:       cnt = 5'd0;
        1:       cnt = 5'($urandom_range(17, 31));
        2:       cnt = 5'd1;
        3:       cnt = 5'd16;
        default: cnt = 5'($urandom_range(2, 16));
      endcase
      write_cfg(CfgCount, cnt);
      if ($urandom_range(0, 7) == 0) begin
        write_cfg($urandom_range(0, 1) ? CfgRsvd2 : CfgRsvd3, CfgDataW'($urandom));
      end
      for (int k = 0; k < phase_len && sent < RandItems; k++) begin
        if (idle_on && $urandom_range(0, 3) == 0) pause_sender();
        kind = ($urandom_range(0, 99) < load_pct) ? KindLoad : KindRequest;
        slot = SlotW'($urandom_range(0, 15));
        pick = $urandom_range(0, 7);
        if (kind == KindLoad) begin
          case (pick)
            0:       amount = '0;
            1:       amount = '1;
            2:       amount = SizeW'($urandom_range(0, 65535));
            default: amount = SizeW'($urandom_range(0, 3000));
          endcase
        end else begin
          case (pick)
            0:       amount = '0;
            1:       amount = '1;
            2:       amount = SizeW'($urandom_range(0, 65535));
            3:       amount = SizeW'($urandom_range(0, 20));
            default: amount = SizeW'($urandom_range(1, 400));
          endcase
        end
        transfer_item(kind, slot, amount, 1'b0, '0);
        sent++;
      end
    end

    wait_drained();
    repeat (25) @(posedge clk_i);
    if (fail_count == 0 && expected_grants.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/fpfa_pkg.sv
src/fpfa_ram.sv
src/fpfa_fit_unit.sv
src/fixed_partition_fit_allocator.sv
verif/tb_fixed_partition_fit_allocator.sv
